/* src/u128dm_pkg.sv */
// Shared types and constants of the 128-bit divide and multiply-divide unit.
// Used by the multiplier, the divider step and the top level; depends on nothing.
`default_nettype none
package u128dm_pkg;

  // Operation codes carried on the input tuser.
  localparam logic OP_DIV   = 1'b0;
  localparam logic OP_SCALE = 1'b1;

  // Result status carried on the output tuser.
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_OVF     = 2'd1,
    ST_INEXACT = 2'd2,
    ST_DIVZERO = 2'd3
  } status_t;

  localparam int unsigned DivSteps = 128;

  // One stage of the restoring divider with the item's side information.
  typedef struct packed {
    logic         valid;
    logic         op;
    logic         exact;
    status_t      status;
    logic [127:0] rem;
    logic [127:0] num;   // dividend bits shift out at the top, quotient bits in
    logic [127:0] dvs;
  } div_stage_t;

endpackage
`default_nettype wire

/* src/u128_divide_and_muldiv_unit.sv */
// Top level of the 128-bit divide and multiply-divide unit.
// Depends on u128dm_pkg, u128dm_mul and u128dm_div_step.
//
// Usage: each input beat carries two 128-bit operands, a 64-bit scale divisor
// and an exactness flag in in_tdata, and the opcode in in_tuser. Opcode divide
// gives quotient and remainder of A by B; opcode scale gives (A * B) / divisor.
// Every input beat yields exactly one output beat, in order, with the status
// on out_tuser and quotient and remainder in out_tdata.
// The pipeline has three multiplier stages, one setup stage, one
// restoring-divider stage per quotient bit (128) and the output register.
// Throughput is one beat per cycle when the receiver does not stall; the 128
// divider stages, each one 129-bit subtract and compare, run fully pipelined.
// The whole pipeline advances together: in_tready is high whenever the output
// register is empty or being taken, so a receiver stall holds every stage and
// nothing is lost or repeated. Reset clears all valid bits; the block keeps
// no other state.
`default_nettype none
module u128_divide_and_muldiv_unit
  import u128dm_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // a_high, a_low, b_high, b_low, scale_divisor, require_exact, zero fill
  input  wire logic [327:0] in_tdata,
  // opcode
  input  wire logic [0:0]   in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // quotient_high, quotient_low, remainder_high, remainder_low
  output logic      [255:0] out_tdata,
  // status
  output logic      [1:0]   out_tuser
);

  typedef struct packed {
    logic         valid;
    logic         op;
    logic         exact;
    logic [127:0] a;
    logic [127:0] b;
    logic [63:0]  c;
  } meta_t;

  logic         ce;
  meta_t        meta_in;
  meta_t        meta_r [0:2];
  logic [255:0] prod;
  div_stage_t   setup_nxt;
  div_stage_t   dst [0:DivSteps];
  logic         out_tvalid_r;
  logic [255:0] out_tdata_r;
  logic [255:0] out_tdata_nxt;
  status_t      out_tuser_r;
  status_t      out_tuser_nxt;

  assign ce        = !out_tvalid_r || out_tready;
  assign in_tready = ce;

  // Input beat unpacked into the item's fields.
  always_comb begin
    meta_in.valid = in_tvalid;
    meta_in.op    = in_tuser[0];
    meta_in.a     = {in_tdata[63:0], in_tdata[127:64]};
    meta_in.b     = {in_tdata[191:128], in_tdata[255:192]};
    meta_in.c     = in_tdata[319:256];
    meta_in.exact = in_tdata[320];
  end

  u128dm_mul u_mul (
    .clk   (clk),
    .ce    (ce),
    .a     (meta_in.a),
    .b     (meta_in.b),
    .prod_r(prod)
  );

  // Side information follows the multiplier stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 3; k++) meta_r[k].valid <= 1'b0;
    end else if (ce) begin
      meta_r[0] <= meta_in;
      meta_r[1] <= meta_r[0];
      meta_r[2] <= meta_r[1];
    end
  end

  // Setup: pick dividend, divisor and starting remainder; flag early errors.
  always_comb begin
    setup_nxt.valid  = meta_r[2].valid;
    setup_nxt.op     = meta_r[2].op;
    setup_nxt.exact  = meta_r[2].exact;
    setup_nxt.status = ST_OK;
    if (meta_r[2].op == OP_DIV) begin
      setup_nxt.rem = '0;
      setup_nxt.num = meta_r[2].a;
      setup_nxt.dvs = meta_r[2].b;
      if (meta_r[2].b == '0) setup_nxt.status = ST_DIVZERO;
    end else begin
      setup_nxt.rem = {64'd0, prod[191:128]};
      setup_nxt.num = prod[127:0];
      setup_nxt.dvs = {64'd0, meta_r[2].c};
      // A quotient beyond 128 bits, including a zero divisor.
      if (prod[255:192] != '0 || prod[191:128] >= meta_r[2].c) setup_nxt.status = ST_OVF;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dst[0].valid <= 1'b0;
    end else if (ce) begin
      dst[0] <= setup_nxt;
    end
  end

  // One divider stage per quotient bit.
  for (genvar k = 0; k < DivSteps; k++) begin : g_div
    u128dm_div_step u_step (
      .clk  (clk),
      .rst_n(rst_n),
      .ce   (ce),
      .s_in (dst[k]),
      .s_r  (dst[k+1])
    );
  end

  // Final status and zeroing of the fields that an error suppresses.
  always_comb begin
    out_tuser_nxt = dst[DivSteps].status;
    out_tdata_nxt = {dst[DivSteps].rem[63:0], dst[DivSteps].rem[127:64],
                     dst[DivSteps].num[63:0], dst[DivSteps].num[127:64]};
    if (dst[DivSteps].status != ST_OK) begin
      out_tdata_nxt = '0;
    end else if (dst[DivSteps].op == OP_SCALE && dst[DivSteps].exact
                 && dst[DivSteps].rem != '0) begin
      out_tuser_nxt = ST_INEXACT;
      out_tdata_nxt = {dst[DivSteps].rem[63:0], 192'd0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (ce) begin
      out_tvalid_r <= dst[DivSteps].valid;
      out_tdata_r  <= out_tdata_nxt;
      out_tuser_r  <= out_tuser_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // Error results carry no quotient.
  a_err_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_OVF || out_tuser == ST_DIVZERO) |-> out_tdata == '0)
    else $error("error result with nonzero data");

  a_inexact : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_INEXACT |-> out_tdata[191:0] == '0
      && out_tdata[255:192] != '0)
    else $error("inexact result malformed");

  // While the output stalls the pipeline takes no new beat.
  a_stall : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input accepted during output stall");

endmodule
`default_nettype wire

/* src/u128dm_mul.sv */
// Three-stage 128 x 128 -> 256 unsigned multiplier built from 32 x 32 products.
// Depends on u128dm_pkg for the house conventions only.
`default_nettype none
module u128dm_mul
  import u128dm_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         ce,
  input  wire logic [127:0] a,
  input  wire logic [127:0] b,
  output logic      [255:0] prod_r
);

  logic [63:0]  pp_r  [0:3][0:3];
  logic [127:0] w_r   [0:1][0:1];
  logic [127:0] w_nxt [0:1][0:1];
  logic [255:0] prod_nxt;

  // First stage: sixteen 32 x 32 partial products.
  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          pp_r[i][j] <= a[32*i +: 32] * b[32*j +: 32];
        end
      end
    end
  end

  // Second stage: each 64 x 64 product from four partial products.
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      for (int j = 0; j < 2; j++) begin
        w_nxt[i][j] = {64'd0, pp_r[2*i][2*j]}
                    + {32'd0, pp_r[2*i+1][2*j], 32'd0}
                    + {32'd0, pp_r[2*i][2*j+1], 32'd0}
                    + {pp_r[2*i+1][2*j+1], 64'd0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      w_r <= w_nxt;
    end
  end

  // Third stage: the four 128-bit products into the full 256-bit result.
  assign prod_nxt = {128'd0, w_r[0][0]}
                  + {64'd0, w_r[1][0], 64'd0}
                  + {64'd0, w_r[0][1], 64'd0}
                  + {w_r[1][1], 128'd0};

  always_ff @(posedge clk) begin
    if (ce) begin
      prod_r <= prod_nxt;
    end
  end

endmodule
`default_nettype wire

/* src/u128dm_div_step.sv */
// One registered step of the 128-bit restoring divider.
// Depends on u128dm_pkg for the stage type.
`default_nettype none
module u128dm_div_step
  import u128dm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       ce,
  input  wire div_stage_t s_in,
  output div_stage_t      s_r
);

  div_stage_t   s_nxt;
  logic [128:0] rem_sh;
  logic [128:0] diff;
  logic         take;

  // Shift in the next dividend bit and subtract the divisor where it fits.
  always_comb begin
    rem_sh = {s_in.rem, s_in.num[127]};
    diff   = rem_sh - {1'b0, s_in.dvs};
    take   = !diff[128];
    s_nxt  = s_in;
    s_nxt.rem = take ? diff[127:0] : rem_sh[127:0];
    s_nxt.num = {s_in.num[126:0], take};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_r.valid <= 1'b0;
    end else if (ce) begin
      s_r <= s_nxt;
    end
  end

endmodule
`default_nettype wire

/* tb/u128_divide_and_muldiv_unit_tb.sv */
// Self-checking bench for the 128-bit divide and multiply-divide unit.
// Depends on u128dm_pkg and the RTL top level u128_divide_and_muldiv_unit.
`default_nettype none
module u128_divide_and_muldiv_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import u128dm_pkg::*;

  typedef struct packed {
    logic         op;
    logic [63:0]  ah, al, bh, bl, c;
    logic         exact;
  } op_beat_t;

  typedef struct packed {
    logic [63:0] qh, ql, rh, rl;
    status_t     st;
  } answer_t;

  localparam int StallLimit = 20000;
  localparam int Latency    = 133;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [327:0] in_tdata = '0;
  logic [0:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [255:0] out_tdata;
  logic [1:0] out_tuser;

  op_beat_t pending_ops[$];
  answer_t  expected_answers[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit recv_hold = 1'b0;
  bit stim_done = 1'b0;
  int quiet_cycles = 0;

  u128_divide_and_muldiv_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Bit-serial restoring division of a 256-bit dividend by a 128-bit divisor.
  function automatic void long_divide(input logic [255:0] num, input logic [127:0] dvs,
                                      output logic [255:0] quo, output logic [127:0] rem);
    logic [128:0] acc;
    acc = '0;
    quo = '0;
    for (int i = 255; i >= 0; i--) begin
      acc = {acc[127:0], num[i]};
      quo = quo << 1;
      if (acc >= {1'b0, dvs}) begin
        acc = acc - {1'b0, dvs};
        quo[0] = 1'b1;
      end
    end
    rem = acc[127:0];
  endfunction

  // Expected answer for one operation.
  function automatic answer_t predict_answer(op_beat_t b);
    answer_t r;
    logic [255:0] prod, quo;
    logic [127:0] rem;
    r = '0;
    r.st = ST_OK;
    if (b.op == OP_DIV) begin
      if ({b.bh, b.bl} == 128'd0) begin
        r.st = ST_DIVZERO;
      end else begin
        long_divide({128'd0, b.ah, b.al}, {b.bh, b.bl}, quo, rem);
        {r.qh, r.ql} = quo[127:0];
        {r.rh, r.rl} = rem;
      end
    end else begin
      prod = {128'd0, b.ah, b.al} * {128'd0, b.bh, b.bl};
      if (prod[255:192] != 64'd0 || prod[191:128] >= b.c) begin
        r.st = ST_OVF;
      end else begin
        long_divide(prod, {64'd0, b.c}, quo, rem);
        r.rl = rem[63:0];
        if (b.exact && rem != 128'd0) r.st = ST_INEXACT;
        else {r.qh, r.ql} = quo[127:0];
      end
    end
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    logic [63:0] v;
    v = {$urandom(), $urandom()};
    case ($urandom_range(0, 5))
      0: v = '0;
      1: v = '1;
      2: v = v >> $urandom_range(1, 63);
      3: v = 64'd1 << $urandom_range(0, 63);
      default: ;
    endcase
    return v;
  endfunction

  function automatic op_beat_t random_op();
    op_beat_t b;
    b.op = logic'($urandom_range(0, 1));
    b.ah = rand64(); b.al = rand64(); b.bh = rand64(); b.bl = rand64();
    b.c = rand64();
    b.exact = logic'($urandom_range(0, 1));
    if (b.op == OP_SCALE && $urandom_range(0, 3) != 0) begin
      // keep the product small enough to fit most of the time
      if ($urandom_range(0, 1)) b.ah = '0; else b.bh = '0;
      if ($urandom_range(0, 1)) b.bh = '0;
      if ($urandom_range(0, 2) == 0 && b.c != 0) begin
        b.bl = b.c; b.bh = '0;  // exact scaling
      end
    end
    return b;
  endfunction

  task automatic add_op(logic op, logic [63:0] ah, al, bh, bl, c, logic exact);
    pending_ops.push_back('{op, ah, al, bh, bl, c, exact});
  endtask

  // Driver: one beat per handshake, with random gaps.
  always @(posedge clk) begin
    if (rst_n) begin
      if (!in_tvalid || in_tready) begin
        if (pending_ops.size() != 0 && $urandom_range(1, 100) > send_idle_pct) begin
          op_beat_t b;
          b = pending_ops.pop_front();
          expected_answers.push_back(predict_answer(b));
          in_tvalid <= 1'b1;
          in_tuser <= b.op;
          in_tdata <= {7'd0, b.exact, b.c, b.bl, b.bh, b.al, b.ah};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver back-pressure.
  always @(posedge clk) begin
    out_tready <= !recv_hold && ($urandom_range(1, 100) > recv_idle_pct);
  end

  // Monitor and stall watchdog.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > StallLimit) begin
        $display("TB_ERROR");
        $finish;
      end
      if (out_tvalid && out_tready) begin
        answer_t act, e;
        act = {out_tdata[63:0], out_tdata[127:64], out_tdata[191:128],
               out_tdata[255:192], status_t'(out_tuser)};
        if (expected_answers.size() == 0) begin
          $error("result beat with nothing expected");
          errors <= errors + 1;
        end else begin
          e = expected_answers.pop_front();
          if (act.qh !== e.qh) $error("quotient_high exp %h got %h", e.qh, act.qh);
          if (act.ql !== e.ql) $error("quotient_low exp %h got %h", e.ql, act.ql);
          if (act.rh !== e.rh) $error("remainder_high exp %h got %h", e.rh, act.rh);
          if (act.rl !== e.rl) $error("remainder_low exp %h got %h", e.rl, act.rl);
          if (act.st !== e.st) $error("status exp %0d got %0d", e.st, act.st);
          if (act !== e) errors <= errors + 1;
        end
      end
    end
  end

  task automatic wait_drained();
    while (pending_ops.size() != 0 || in_tvalid || expected_answers.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extremes, both operations and each special case.
    add_op(OP_DIV, '1, '1, '1, '1, '0, 1'b0);
    add_op(OP_DIV, '1, '1, '0, 64'd1, '1, 1'b1);
    add_op(OP_DIV, '1, '1, '0, '0, '1, 1'b0);        // divide by zero
    add_op(OP_DIV, '0, '0, '0, '0, '0, 1'b1);
    add_op(OP_DIV, '0, 64'd5, '1, '1, '0, 1'b0);
    add_op(OP_DIV, 64'h8000_0000_0000_0000, '0, '0, 64'd3, 64'd9, 1'b1);
    add_op(OP_DIV, '1, '0, 64'd1, '0, '0, 1'b0);
    add_op(OP_SCALE, '0, 64'd6, '0, 64'd7, '0, 1'b0);  // zero divisor
    add_op(OP_SCALE, '0, 64'd6, '0, 64'd7, 64'd3, 1'b1);
    add_op(OP_SCALE, '0, 64'd6, '0, 64'd7, 64'd5, 1'b1); // inexact
    add_op(OP_SCALE, '0, 64'd6, '0, 64'd7, 64'd5, 1'b0);
    add_op(OP_SCALE, '1, '1, '1, '1, '1, 1'b0);          // quotient too wide
    add_op(OP_SCALE, '0, '1, '0, '1, '1, 1'b1);
    add_op(OP_SCALE, '1, '1, '0, 64'd1, 64'd2, 1'b0);
    add_op(OP_SCALE, '0, '1, '0, '1, 64'hFFFF_FFFF_FFFF_FFFE, 1'b0);
    add_op(OP_SCALE, '0, '0, '1, '1, 64'd1, 1'b1);
    add_op(OP_SCALE, 64'd1, '0, 64'd1, '0, 64'd1, 1'b0);  // high word equals divisor
    wait_drained();

    // Random phases with the two idling profiles, then none.
    send_idle_pct = 12; recv_idle_pct = 75;
    repeat (180) pending_ops.push_back(random_op());
    wait_drained();
    send_idle_pct = 75; recv_idle_pct = 12;
    repeat (180) pending_ops.push_back(random_op());
    wait_drained();
    send_idle_pct = 0; recv_idle_pct = 0;
    repeat (170) pending_ops.push_back(random_op());

    // Long receiver hold-off so the pipeline fills and stalls the input.
    recv_hold = 1'b1;
    repeat (400) @(posedge clk);
    recv_hold = 1'b0;
    wait_drained();

    repeat (Latency + 20) @(posedge clk);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
`default_nettype wire

/* u128_divide_and_muldiv_unit.f */
src/u128dm_pkg.sv
src/u128dm_mul.sv
src/u128dm_div_step.sv
src/u128_divide_and_muldiv_unit.sv
tb/u128_divide_and_muldiv_unit_tb.sv
